/* hdl/brfb_pkg.sv */
// Shared types and constants for the byte ring FIFO batch block.
`timescale 1ns / 1ps
`default_nettype none

package brfb_pkg;

    // Default ring depth in bytes (power of two, 2 to 64)
    localparam int BRFB_DEPTH_DEF = 64;

    // Width of count fields on the stream interface
    localparam int CNT_W = 7;

    // Saturation value of the per-batch accepted counter
    localparam logic [CNT_W-1:0] ACC_MAX = {CNT_W{1'b1}};

    // Depth of the command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Request kinds as they arrive on tuser
    localparam logic [1:0] KIND_PUT   = 2'd0;
    localparam logic [1:0] KIND_GET   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Operations handed from front to back
    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_GET,
        CMD_QUERY
    } cmd_op_t;

    // One classified request
    typedef struct packed {
        cmd_op_t          op;
        logic [7:0]       data;
        logic             last;
        logic [CNT_W-1:0] count;   // saturated at DEPTH; used by gets
    } cmd_t;

endpackage

`default_nettype wire

/* hdl/byte_ring_fifo_batch.sv */
// Top level: byte FIFO on a power-of-two ring with batched puts and counted gets.
// A put-end or query result is registered as its command leaves the command queue;
// a get's first byte passes the RAM read register, then the output register.
// Throughput: one put per cycle outside a get, if put-ends find the output free; get bytes
// stream at one per cycle from the registered-read ring RAM while the output side takes them.
// Reset: pointers, batch counters, queue and output are cleared; the ring RAM is not.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_fifo_batch
    import brfb_pkg::*;
#(
    parameter int DEPTH = BRFB_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // put_byte[7:0], request_count[14:8], pad
    input  wire logic [1:0]  s_axis_tuser,   // kind[1:0]
    input  wire logic        s_axis_tlast,   // batch_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_byte[7:0], moved_count[14:8], pad
    output logic             m_axis_tuser,   // has_byte
    output logic             m_axis_tlast    // final_res
);

    cmd_t             cmd;
    logic             cmd_valid;
    logic             cmd_ready;
    logic [7:0]       res_byte;
    logic [CNT_W-1:0] res_count;

    brfb_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_byte   (s_axis_tdata[7:0]),
        .in_last   (s_axis_tlast),
        .in_count  (s_axis_tdata[14:8]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    brfb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (res_byte),
        .out_has   (m_axis_tuser),
        .out_count (res_count),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, res_count, res_byte};

endmodule

`default_nettype wire

/* hdl/brfb_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module brfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/brfb_cmd_queue.sv */
// Small register queue that carries classified requests from front to back.
`timescale 1ns / 1ps
`default_nettype none

module brfb_cmd_queue
    import brfb_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_data,
    output logic      full,
    input  wire logic pop,
    output logic      pop_valid,
    output cmd_t      pop_data
);

    cmd_t            entry_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_AW:0]   count_reg;
    logic [Q_AW:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full      = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (Q_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Occupancy never passes the queue depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (Q_AW+1)'(Q_DEPTH))
        else $error("command queue occupancy overflow");

    // Occupancy tracks the pointer distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[Q_AW-1:0] == (wr_ptr_reg - rd_ptr_reg)))
        else $error("command queue pointers and count disagree");

endmodule

`default_nettype wire

/* hdl/brfb_front.sv */
// Front end: accepts stream requests, classifies them and queues commands.
`timescale 1ns / 1ps
`default_nettype none

module brfb_front
    import brfb_pkg::*;
#(
    parameter int DEPTH = BRFB_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_kind,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    input  wire logic [CNT_W-1:0] in_count,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output cmd_t                  cmd
);

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    cmd_t class_cmd;
    logic class_keep;
    logic q_full;
    logic q_push;

    // Classify the request; unknown kinds are taken and discarded
    always_comb
    begin
        class_cmd.data  = in_byte;
        class_cmd.last  = in_last;
        class_cmd.count = (in_count > DEPTH_C) ? DEPTH_C : in_count;
        class_cmd.op    = CMD_PUT;
        class_keep      = 1'b1;
        case (in_kind)
            KIND_PUT:   class_cmd.op = CMD_PUT;
            KIND_GET:   class_cmd.op = CMD_GET;
            KIND_QUERY: class_cmd.op = CMD_QUERY;
            default:    class_keep   = 1'b0;
        endcase
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready && class_keep;

    brfb_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (class_cmd),
        .full      (q_full),
        .pop       (cmd_ready),
        .pop_valid (cmd_valid),
        .pop_data  (cmd)
    );

endmodule

`default_nettype wire

/* hdl/brfb_back.sv */
// Back end: owns the ring pointers and storage, executes commands, drives results.
`timescale 1ns / 1ps
`default_nettype none

module brfb_back
    import brfb_pkg::*;
#(
    parameter int DEPTH = BRFB_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire cmd_t             cmd,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_has,
    output logic [CNT_W-1:0]      out_count,
    output logic                  out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] DEPTH_L = PW'(DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_GET
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [PW-1:0]    wp_reg;
    logic [PW-1:0]    wp_next;
    logic [PW-1:0]    rp_reg;
    logic [PW-1:0]    rp_next;
    logic [CNT_W-1:0] acc_reg;
    logic [CNT_W-1:0] acc_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic [PW-1:0]    remain_reg;
    logic [PW-1:0]    remain_next;
    logic [PW-1:0]    total_reg;
    logic [PW-1:0]    total_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_has_reg;
    logic             out_has_next;
    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W-1:0] out_count_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic [PW-1:0]    level;
    logic             out_free;
    logic             put_ok;
    logic [CNT_W-1:0] acc_new;
    logic [PW-1:0]    req_sat;
    logic [PW-1:0]    get_cnt;
    logic             ram_we;
    logic             ram_re;
    logic [7:0]       ram_rdata;

    // Fill level and derived request figures
    assign level    = wp_reg - rp_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign put_ok   = !dropped_reg && (level != DEPTH_L);
    assign acc_new  = (put_ok && (acc_reg != ACC_MAX)) ? acc_reg + CNT_W'(1) : acc_reg;
    assign req_sat  = cmd.count[PW-1:0];
    assign get_cnt  = (req_sat < level) ? req_sat : level;

    // Command sequencer
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        acc_next       = acc_reg;
        dropped_next   = dropped_reg;
        remain_next    = remain_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_has_next   = out_has_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        cmd_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        CMD_PUT:
                        begin
                            if (!cmd.last || out_free)
                            begin
                                cmd_ready = 1'b1;
                                if (put_ok)
                                begin
                                    ram_we  = 1'b1;
                                    wp_next = wp_reg + PW'(1);
                                end
                                else
                                begin
                                    dropped_next = 1'b1;
                                end
                                acc_next = acc_new;
                                if (cmd.last)
                                begin
                                    out_valid_next = 1'b1;
                                    out_byte_next  = '0;
                                    out_has_next   = 1'b0;
                                    out_count_next = acc_new;
                                    out_last_next  = 1'b1;
                                    acc_next       = '0;
                                    dropped_next   = 1'b0;
                                end
                            end
                        end
                        CMD_GET:
                        begin
                            if (get_cnt != '0)
                            begin
                                // first read goes out with the pop
                                cmd_ready   = 1'b1;
                                ram_re      = 1'b1;
                                rp_next     = rp_reg + PW'(1);
                                remain_next = get_cnt - PW'(1);
                                total_next  = get_cnt;
                                state_next  = ST_GET;
                            end
                            else if (out_free)
                            begin
                                cmd_ready      = 1'b1;
                                out_valid_next = 1'b1;
                                out_byte_next  = '0;
                                out_has_next   = 1'b0;
                                out_count_next = '0;
                                out_last_next  = 1'b1;
                                if (wp_reg == rp_reg)
                                begin
                                    wp_next = '0;
                                    rp_next = '0;
                                end
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (out_free)
                            begin
                                cmd_ready      = 1'b1;
                                out_valid_next = 1'b1;
                                out_byte_next  = '0;
                                out_has_next   = 1'b0;
                                out_count_next = CNT_W'(level);
                                out_last_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_GET:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_has_next   = 1'b1;
                    out_count_next = CNT_W'(total_reg);
                    out_last_next  = (remain_reg == '0);
                    if (remain_reg == '0)
                    begin
                        state_next = ST_IDLE;
                        if (wp_reg == rp_reg)
                        begin
                            wp_next = '0;
                            rp_next = '0;
                        end
                    end
                    else
                    begin
                        ram_re      = 1'b1;
                        rp_next     = rp_reg + PW'(1);
                        remain_next = remain_reg - PW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, pointers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            acc_reg       <= '0;
            dropped_reg   <= 1'b0;
            remain_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_has_reg   <= 1'b0;
            out_count_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            acc_reg       <= acc_next;
            dropped_reg   <= dropped_next;
            remain_reg    <= remain_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_has_reg   <= out_has_next;
            out_count_reg <= out_count_next;
            out_last_reg  <= out_last_next;
        end
    end

    brfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg[AW-1:0]),
        .wdata (cmd.data),
        .re    (ram_re),
        .raddr (rp_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_has   = out_has_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

    // Fill level never exceeds the ring size
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= DEPTH_L)
        else $error("ring fill level above depth");

    // Bytes still to read in a get stay below the get's byte total
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GET) |-> (remain_reg < total_reg))
        else $error("get remainder out of range");

    // A byte-carrying result always reports a nonzero delivery count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_has_reg) |-> (out_count_reg != '0))
        else $error("data result with zero count");

    // No write to the ring while a get is reading it out
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GET) |-> !ram_we)
        else $error("ring write during get");

endmodule

`default_nettype wire
